FILE: rtl/rank_select_slot_tree_core_defines.svh
// Assertion macros used by the top-level block to check its own control logic.
`ifndef RANK_SELECT_SLOT_TREE_CORE_DEFINES_SVH
`define RANK_SELECT_SLOT_TREE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RSST_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rsst same-cycle check failed");
`define RSST_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rsst next-cycle check failed");
`else
`define RSST_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define RSST_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

FILE: rtl/rsst_pkg.sv
`default_nettype none

package rsst_pkg;

  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 10;
  localparam int RANK_W  = 11;
  localparam int COUNT_W = 11;

  localparam logic [MODE_W-1:0] MODE_MARK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SELECT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] range_low;
    logic [SLOT_W-1:0] range_high;
    logic [RANK_W-1:0] rank;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] used_count;
    logic [SLOT_W-1:0]  found_slot;
    logic               not_found;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK_LEAF,
    ST_MARK_UP,
    ST_COUNT,
    ST_SEL_ROOT,
    ST_SEL_DOWN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic mark_step;
    logic count_step;
    logic sel_root;
    logic sel_step;
    logic clear_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic leaf_used;
    logic at_root;
    logic a_lt_b;
    logic sel_bad;
    logic sel_leaf;
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/rsst_ctrl.sv
`default_nettype none

module rsst_ctrl import rsst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [MODE_W-1:0] req_mode,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  status_t           status,
  output cmd_t              cmd
);

  state_t state, state_next;
  logic   clear_reply, clear_reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clear_reply <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clear_reply <= clear_reply_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next       = state;
    clear_reply_next = clear_reply;
    cmd              = '0;
    req_stall        = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clr_last) begin
          state_next = clear_reply ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          case (req_mode)
            MODE_MARK:   state_next = ST_MARK_LEAF;
            MODE_COUNT:  state_next = ST_COUNT;
            MODE_SELECT: state_next = ST_SEL_ROOT;
            default: begin
              state_next       = ST_CLEAR;
              clear_reply_next = 1'b1;
            end
          endcase
        end
      end
      ST_MARK_LEAF: begin
        if (status.leaf_used) begin
          state_next = ST_EMIT;
        end else begin
          cmd.mark_step = 1'b1;
          state_next    = ST_MARK_UP;
        end
      end
      ST_MARK_UP: begin
        cmd.mark_step = 1'b1;
        if (status.at_root) begin
          state_next = ST_EMIT;
        end
      end
      ST_COUNT: begin
        cmd.count_step = 1'b1;
        if (!status.a_lt_b) begin
          state_next = ST_EMIT;
        end
      end
      ST_SEL_ROOT: begin
        cmd.sel_root = 1'b1;
        state_next   = status.sel_bad ? ST_EMIT : ST_SEL_DOWN;
      end
      ST_SEL_DOWN: begin
        cmd.sel_step = 1'b1;
        if (status.sel_leaf) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_out     = 1'b1;
          clear_reply_next = 1'b0;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/rsst_dpath.sv
`default_nettype none

module rsst_dpath import rsst_pkg::*; #(
  parameter int LOG_SLOTS = 10
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  cmd_t    cmd,
  output status_t status,
  output rsp_t    rsp
);

  localparam int SLOTS = 1 << LOG_SLOTS;
  localparam int DEPTH = 2 * SLOTS;
  localparam int NW    = LOG_SLOTS + 1;
  localparam int CW    = LOG_SLOTS + 1;
  localparam int KW    = (CW > RANK_W) ? CW : RANK_W;
  localparam int IW    = (LOG_SLOTS > SLOT_W) ? LOG_SLOTS : SLOT_W;

  logic [CW-1:0] mem [DEPTH];
  logic [NW-1:0] rd_addr0, rd_addr1, wr_addr;
  logic [CW-1:0] rd0, rd1, wr_data;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0 <= mem[rd_addr0];
    rd1 <= mem[rd_addr1];
  end

  logic [MODE_W-1:0] mode_q;
  logic [NW-1:0]     n_q, clr_q;
  logic [NW:0]       a_q, b_q;
  logic              pa_q, pb_q, nf_q;
  logic [CW-1:0]     total_q, half_q;
  logic [KW-1:0]     k_q;

  logic [IW-1:0] slot_ext;
  logic [IW:0]   lo_ext, hi_ext, hi_c, last_slot;
  logic          empty;
  logic [NW-1:0] leaf_in;
  logic [NW:0]   a_in, b_in, a_adv, b_adv, b_dec;
  logic [CW-1:0] total_next, free_total, left_free;
  logic          go_left;
  logic [NW-1:0] n_next;
  logic [KW-1:0] k_down;
  rsp_t          rsp_next;

  assign slot_ext  = IW'(req.slot);
  assign leaf_in   = {1'b1, slot_ext[LOG_SLOTS-1:0]};
  assign lo_ext    = (IW+1)'(req.range_low);
  assign hi_ext    = (IW+1)'(req.range_high);
  assign last_slot = (IW+1)'(SLOTS - 1);
  assign hi_c      = (hi_ext > last_slot) ? last_slot : hi_ext;
  assign empty     = lo_ext > hi_c;
  assign a_in      = {2'b01, lo_ext[LOG_SLOTS-1:0]};
  assign b_in      = {2'b01, hi_c[LOG_SLOTS-1:0]} + (NW+1)'(1);

  assign a_adv      = (a_q + (NW+1)'(a_q[0])) >> 1;
  assign b_adv      = (b_q - (NW+1)'(b_q[0])) >> 1;
  assign b_dec      = b_q - (NW+1)'(1);
  assign total_next = total_q + (pa_q ? rd0 : '0) + (pb_q ? rd1 : '0);

  assign free_total = CW'(SLOTS) - rd0;
  assign left_free  = half_q - rd0;
  assign go_left    = k_q <= KW'(left_free);
  assign n_next     = {n_q[NW-2:0], ~go_left};
  assign k_down     = k_q - KW'(left_free);

  assign status.leaf_used = rd0 != '0;
  assign status.at_root   = n_q == NW'(1);
  assign status.a_lt_b    = a_q < b_q;
  assign status.sel_bad   = (k_q == '0) || (k_q > KW'(free_total));
  assign status.sel_leaf  = n_next[NW-1];
  assign status.clr_last  = &clr_q;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = n_q;
    wr_data  = rd0 + CW'(1);
    rd_addr1 = b_dec[NW-1:0];
    rd_addr0 = a_q[NW-1:0];
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (cmd.mark_step) begin
      wr_en = 1'b1;
    end
    if (cmd.accept) begin
      rd_addr0 = (req.mode == MODE_MARK) ? leaf_in : NW'(1);
    end else if (cmd.mark_step) begin
      rd_addr0 = n_q >> 1;
    end else if (cmd.sel_root) begin
      rd_addr0 = {n_q[NW-2:0], 1'b0};
    end else if (cmd.sel_step) begin
      rd_addr0 = {n_next[NW-2:0], 1'b0};
    end
  end

  always_comb begin
    rsp_next = '0;
    case (mode_q)
      MODE_COUNT: rsp_next.used_count = COUNT_W'(total_q);
      MODE_SELECT: begin
        rsp_next.not_found = nf_q;
        if (!nf_q) begin
          rsp_next.found_slot = SLOT_W'(n_q[LOG_SLOTS-1:0]);
        end
      end
      default: rsp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_q <= '0;
    end else if (cmd.clear_step) begin
      clr_q <= clr_q + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q  <= req.mode;
      n_q     <= (req.mode == MODE_MARK) ? leaf_in : NW'(1);
      a_q     <= empty ? '0 : a_in;
      b_q     <= empty ? '0 : b_in;
      pa_q    <= 1'b0;
      pb_q    <= 1'b0;
      total_q <= '0;
      k_q     <= KW'(req.rank);
      half_q  <= CW'(SLOTS >> 1);
      nf_q    <= 1'b0;
    end
    if (cmd.mark_step) begin
      n_q <= n_q >> 1;
    end
    if (cmd.count_step) begin
      total_q <= total_next;
      if (status.a_lt_b) begin
        pa_q <= a_q[0];
        pb_q <= b_q[0];
        a_q  <= a_adv;
        b_q  <= b_adv;
      end else begin
        pa_q <= 1'b0;
        pb_q <= 1'b0;
      end
    end
    if (cmd.sel_root) begin
      nf_q <= status.sel_bad;
    end
    if (cmd.sel_step) begin
      n_q    <= n_next;
      k_q    <= go_left ? k_q : k_down;
      half_q <= half_q >> 1;
    end
    if (cmd.load_out) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rank_select_slot_tree_core.sv
// Count tree over 2**LOG_SLOTS slots held in one on-chip memory of 2**(LOG_SLOTS+1)
// counters. Each request beat gives exactly one response beat: mark sets a slot used
// (marking a used slot again changes nothing), count returns the used slots in an
// inclusive range with the high end clamped to the last slot, select returns the
// slot of the rank-th free slot or flags not_found, and clear empties the tree.
// Mark, select and count walk the tree level by level, and every tree level costs one
// registered memory access; a mark of a used slot, an empty count range or a failed
// select ends without walking the tree. Clear sweeps the memory one counter per cycle,
// and the same sweep runs after reset; request stall stays high during either sweep.
// A finished response waits in an output register, so the next request is taken
// while it is still stalled.
`default_nettype none
`include "rank_select_slot_tree_core_defines.svh"

module rank_select_slot_tree_core import rsst_pkg::*; #(
  parameter int LOG_SLOTS = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  rsst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req.mode),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rsst_dpath #(
    .LOG_SLOTS (LOG_SLOTS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

  `RSST_ASSERT_IMPLIES(a_load_free, clk, rst, cmd.load_out, !rsp_valid || !rsp_stall)
  `RSST_ASSERT_NEXT(a_load_shows, clk, rst, cmd.load_out, rsp_valid)
  `RSST_ASSERT_IMPLIES(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))
  `RSST_ASSERT_IMPLIES(a_nf_zero, clk, rst, rsp_valid && rsp.not_found, rsp.found_slot == '0)
  `RSST_ASSERT_IMPLIES(a_sweep_stall, clk, rst, $fell(rst), req_stall)

endmodule

`default_nettype wire
